/* hw/rtl/tce_pkg.sv */
// Package for the tiny instruction execute block.
// Holds the beat types, opcodes, codes and sizes shared by tce_seq_unit and the top level.
// Depends on nothing.
`default_nettype none

package tce_pkg;

    localparam int REG_COUNT     = 16;
    localparam int REG_IW        = $clog2(REG_COUNT);
    localparam int TABLE_ENTRIES = 3;
    localparam int TBL_DEPTH     = 3;
    localparam int TBL_IW        = $clog2(TBL_DEPTH);
    localparam int TBL_LIMIT     = (TABLE_ENTRIES < TBL_DEPTH) ? TABLE_ENTRIES : TBL_DEPTH;
    localparam int DATA_W        = 32;
    localparam int SEQ_STEPS     = DATA_W;
    localparam int SEQ_CW        = $clog2(SEQ_STEPS);
    localparam int CFG_IW        = 3;

    localparam logic [REG_IW-1:0] REG_TOTAL = REG_IW'(7);
    localparam logic [3:0]        CNT_MAX   = 4'hF;

    localparam logic [7:0] OP_MOV_RR = 8'h00;
    localparam logic [7:0] OP_MOV_RI = 8'h01;
    localparam logic [7:0] OP_CMP_RR = 8'h02;
    localparam logic [7:0] OP_CMP_RI = 8'h03;
    localparam logic [7:0] OP_ADD_RR = 8'h04;
    localparam logic [7:0] OP_SUB_RR = 8'h05;
    localparam logic [7:0] OP_MUL_RR = 8'h06;
    localparam logic [7:0] OP_DIV_RR = 8'h07;
    localparam logic [7:0] OP_JMP    = 8'h08;
    localparam logic [7:0] OP_JEQ    = 8'h09;
    localparam logic [7:0] OP_JNE    = 8'h0A;
    localparam logic [7:0] OP_JLT    = 8'h0D;
    localparam logic [7:0] OP_JGE    = 8'h0E;
    localparam logic [7:0] OP_LOAD   = 8'h0F;
    localparam logic [7:0] OP_ADD_RI = 8'h10;
    localparam logic [7:0] OP_SUB_RI = 8'h11;
    localparam logic [7:0] OP_HALT   = 8'hFF;

    localparam logic [2:0] ALU_NONE = 3'd0;
    localparam logic [2:0] ALU_ADD  = 3'd1;
    localparam logic [2:0] ALU_SUB  = 3'd2;
    localparam logic [2:0] ALU_MUL  = 3'd3;
    localparam logic [2:0] ALU_DIV  = 3'd4;
    localparam logic [2:0] ALU_CMP  = 3'd5;

    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_LT = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_TOTAL = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_DIR0  = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] CFG_DIR1  = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] CFG_DIR2  = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] CFG_DIST0 = CFG_IW'(4);
    localparam logic [CFG_IW-1:0] CFG_DIST1 = CFG_IW'(5);
    localparam logic [CFG_IW-1:0] CFG_DIST2 = CFG_IW'(6);

    typedef struct packed {
        logic [7:0] opcode;
        logic [3:0] field_x;
        logic [3:0] field_y;
    } t_in;

    typedef struct packed {
        logic [7:0]         next_fetch;
        logic [15:0]        program_counter;
        logic               zero_flag;
        logic               negative_flag;
        logic [2:0]         alu_signal;
        logic               main_write;
        logic [3:0]         main_index;
        logic signed [31:0] main_value;
        logic               counter_write;
        logic [3:0]         counter_index;
        logic [3:0]         counter_value;
        logic               halted;
    } t_out;

    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_seq_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_seq_rsp;

endpackage

`default_nettype wire

/* hw/rtl/tce_seq_unit.sv */
// Iterative multiply / signed divide unit, one bit per cycle over a shared 33-bit adder.
// Depends on tce_pkg.
`default_nettype none

module tce_seq_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tce_pkg::t_seq_req i_req,
    output tce_pkg::t_seq_rsp      o_rsp
);
    import tce_pkg::*;

    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_sh;
    logic [DATA_W-1:0] r_opd;
    logic [SEQ_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              r_div;
    logic              r_neg;
    logic              r_zero;

    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_add_a;
    logic [DATA_W:0]   w_add_b;
    logic [DATA_W:0]   w_sum;

    assign w_rem_sh = {r_acc, r_sh[DATA_W-1]};
    assign w_add_a  = r_div ? w_rem_sh : {1'b0, r_acc};
    assign w_add_b  = r_div ? ~{1'b0, r_opd} :
                      {1'b0, (r_sh[0] ? r_opd : {DATA_W{1'b0}})};
    assign w_sum    = w_add_a + w_add_b + {{DATA_W{1'b0}}, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == SEQ_CW'(SEQ_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + SEQ_CW'(1);
                if (r_cnt == SEQ_CW'(SEQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div  <= i_req.is_div;
            r_acc  <= '0;
            r_neg  <= i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
            r_zero <= (i_req.b == '0);
            if (i_req.is_div) begin
                r_sh  <= i_req.a[DATA_W-1] ? (~i_req.a + DATA_W'(1)) : i_req.a;
                r_opd <= i_req.b[DATA_W-1] ? (~i_req.b + DATA_W'(1)) : i_req.b;
            end else begin
                r_sh  <= i_req.b;
                r_opd <= i_req.a;
            end
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_sum[DATA_W]) begin
                    r_acc <= w_sum[DATA_W-1:0];
                    r_sh  <= {r_sh[DATA_W-2:0], 1'b1};
                end else begin
                    r_acc <= w_rem_sh[DATA_W-1:0];
                    r_sh  <= {r_sh[DATA_W-2:0], 1'b0};
                end
            end else begin
                r_acc <= w_sum[DATA_W-1:0];
                r_sh  <= r_sh >> 1;
                r_opd <= r_opd << 1;
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (!r_div) begin
            o_rsp.result = r_acc;
        end else if (r_zero) begin
            o_rsp.result = '0;
        end else if (r_neg) begin
            o_rsp.result = ~r_sh + DATA_W'(1);
        end else begin
            o_rsp.result = r_sh;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tiny_cpu_instruction_execute_top.sv */
// Top level of the tiny instruction execute block: register file, decode, sequencer.
// Depends on tce_pkg and tce_seq_unit.
//
//   channel | direction | handshake                 | beat
//   in      | input     | i_in_valid / o_in_stall   | tce_pkg::t_in
//   out     | output    | o_out_valid / i_out_stall | tce_pkg::t_out
//   cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// Each instruction steps through accept, execute, counter write-back, main write-back and
// result load, and the next is not accepted before the result load; the result beat becomes valid at the result load.
// mul and div wait between execute and counter write-back for the bit-serial multiply/divide unit.
// Reset is synchronous and clears the control state and the register valid bits; no clearing pass is needed.
// A stalled result beat holds in the output register; the next instruction may be accepted
// and run meanwhile, and waits at its end until the output register frees.
`default_nettype none

module tiny_cpu_instruction_execute_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire tce_pkg::t_in                i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output tce_pkg::t_out                    o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [tce_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [tce_pkg::DATA_W-1:0]  i_cfg_data
);
    import tce_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_ITER = 6'b000100,
        S_WBC  = 6'b001000,
        S_WBM  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_total;
    logic [1:0]        r_dir  [TBL_DEPTH];
    logic [15:0]       r_dist [TBL_DEPTH];

    logic [DATA_W-1:0] r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [DATA_W-1:0] r_rd_a, r_rd_b;
    logic              r_a_vld, r_b_vld;

    t_in               r_instr;
    t_out              r_res, n_res;
    t_out              r_out;
    logic              r_out_valid;

    logic [15:0]       r_pc, n_pc;
    logic [1:0]        r_cmp, n_cmp;
    logic              r_toggle, n_toggle;
    logic [3:0]        r_dir_cnt, n_dir_cnt;
    logic [3:0]        r_dist_cnt, n_dist_cnt;
    logic              r_halt, n_halt;
    logic              n_iter;

    logic              w_in_acc;
    logic              w_out_load;
    logic [DATA_W-1:0] w_a, w_b, w_imm;
    logic [DATA_W-1:0] w_cmp_b, w_add_b, w_add;
    logic              w_sub;
    logic [1:0]        w_code;
    logic              w_rf_we;
    logic [REG_IW-1:0] w_rf_wa;
    logic [DATA_W-1:0] w_rf_wd;

    t_seq_req          w_req;
    t_seq_rsp          w_rsp;

    tce_seq_unit u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // register 7 falls back to the total distance setting until written
    assign w_a = r_a_vld ? r_rd_a :
                 ((r_instr.field_x == REG_TOTAL) ? r_total : '0);
    assign w_b = r_b_vld ? r_rd_b :
                 ((r_instr.field_y == REG_TOTAL) ? r_total : '0);
    assign w_imm = {{(DATA_W-4){1'b0}}, r_instr.field_y};

    assign w_cmp_b = (r_instr.opcode == OP_CMP_RI) ? w_imm : w_b;
    assign w_code  = (w_a == w_cmp_b) ? CMP_EQ :
                     (($signed(w_a) < $signed(w_cmp_b)) ? CMP_LT : CMP_GT);
    assign w_sub   = (r_instr.opcode == OP_SUB_RR) || (r_instr.opcode == OP_SUB_RI);
    assign w_add_b = ((r_instr.opcode == OP_ADD_RI) || (r_instr.opcode == OP_SUB_RI)) ?
                     w_imm : w_b;
    assign w_add   = w_a + (w_sub ? ~w_add_b : w_add_b) + {{(DATA_W-1){1'b0}}, w_sub};

    assign w_req.start  = (r_state == S_EXEC) && n_iter;
    assign w_req.is_div = (r_instr.opcode == OP_DIV_RR);
    assign w_req.a      = w_a;
    assign w_req.b      = w_b;

    always_comb begin
        logic jump;
        logic [3:0] cv;
        jump       = 1'b0;
        cv         = '0;
        n_iter     = 1'b0;
        n_pc       = r_pc;
        n_cmp      = r_cmp;
        n_toggle   = r_toggle;
        n_dir_cnt  = r_dir_cnt;
        n_dist_cnt = r_dist_cnt;
        n_halt     = r_halt;
        n_res      = '0;
        if (!r_halt) begin
            n_pc = r_pc + 16'd1;
            unique case (r_instr.opcode) inside
                OP_HALT: n_halt = 1'b1;
                OP_MOV_RR, OP_MOV_RI: begin
                    n_res.main_write = 1'b1;
                    n_res.main_index = r_instr.field_x;
                    n_res.main_value = (r_instr.opcode == OP_MOV_RI) ? w_imm : w_b;
                end
                OP_CMP_RR, OP_CMP_RI: begin
                    n_cmp               = w_code;
                    n_res.alu_signal    = ALU_CMP;
                    n_res.zero_flag     = (w_code == CMP_EQ);
                    n_res.negative_flag = (w_code == CMP_LT);
                end
                OP_ADD_RR, OP_ADD_RI, OP_SUB_RR, OP_SUB_RI: begin
                    n_res.main_write = 1'b1;
                    n_res.main_index = r_instr.field_x;
                    n_res.main_value = w_add;
                    n_res.alu_signal = w_sub ? ALU_SUB : ALU_ADD;
                end
                OP_MUL_RR, OP_DIV_RR: begin
                    n_iter           = 1'b1;
                    n_res.main_write = 1'b1;
                    n_res.main_index = r_instr.field_x;
                    n_res.alu_signal = (r_instr.opcode == OP_DIV_RR) ? ALU_DIV : ALU_MUL;
                end
                OP_JMP: jump = 1'b1;
                OP_JEQ: jump = (r_cmp == CMP_EQ);
                OP_JNE: jump = (r_cmp != CMP_EQ);
                OP_JLT: jump = (r_cmp == CMP_LT);
                OP_JGE: jump = (r_cmp == CMP_EQ) || (r_cmp == CMP_GT);
                OP_LOAD: begin
                    n_res.main_write    = 1'b1;
                    n_res.main_index    = r_instr.field_x;
                    n_res.counter_write = 1'b1;
                    n_res.counter_index = r_instr.field_y;
                    n_toggle            = ~r_toggle;
                    if (!r_toggle) begin
                        cv = r_dir_cnt;
                        if (cv < 4'(TBL_LIMIT)) begin
                            n_res.main_value = {{(DATA_W-2){1'b0}}, r_dir[cv[TBL_IW-1:0]]};
                        end
                        if (r_dir_cnt != CNT_MAX) begin
                            n_dir_cnt = r_dir_cnt + 4'd1;
                        end
                    end else begin
                        cv = r_dist_cnt;
                        if (cv < 4'(TBL_LIMIT)) begin
                            n_res.main_value = {{(DATA_W-16){1'b0}}, r_dist[cv[TBL_IW-1:0]]};
                        end
                        if (r_dist_cnt != CNT_MAX) begin
                            n_dist_cnt = r_dist_cnt + 4'd1;
                        end
                    end
                    n_res.counter_value = cv;
                end
                default: ;
            endcase
            if (jump) begin
                n_pc = {8'h00, r_instr.field_x, r_instr.field_y} + 16'd1;
            end
        end
        n_res.program_counter = n_pc;
        n_res.next_fetch      = 8'(n_pc - 16'd1);
        n_res.halted          = n_halt;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_EXEC;
            S_EXEC: n_state = n_iter ? S_ITER : S_WBC;
            S_ITER: if (w_rsp.done) n_state = S_WBC;
            S_WBC:  n_state = S_WBM;
            S_WBM:  n_state = S_DONE;
            S_DONE: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // counter write lands first, main write second
    always_comb begin
        w_rf_we = 1'b0;
        w_rf_wa = r_res.main_index;
        w_rf_wd = r_res.main_value;
        if (r_state == S_WBC) begin
            w_rf_we = r_res.counter_write;
            w_rf_wa = r_res.counter_index;
            w_rf_wd = {{(DATA_W-4){1'b0}}, r_res.counter_value};
        end else if (r_state == S_WBM) begin
            w_rf_we = r_res.main_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pc        <= 16'd1;
            r_cmp       <= CMP_EQ;
            r_toggle    <= 1'b0;
            r_dir_cnt   <= '0;
            r_dist_cnt  <= '0;
            r_halt      <= 1'b0;
            r_rf_vld    <= '0;
            r_total     <= '0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
                r_dir[i]  <= '0;
                r_dist[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EXEC) begin
                r_pc       <= n_pc;
                r_cmp      <= n_cmp;
                r_toggle   <= n_toggle;
                r_dir_cnt  <= n_dir_cnt;
                r_dist_cnt <= n_dist_cnt;
                r_halt     <= n_halt;
            end
            if (w_rf_we) begin
                r_rf_vld[w_rf_wa] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TOTAL: r_total   <= i_cfg_data;
                    CFG_DIR0:  r_dir[0]  <= i_cfg_data[1:0];
                    CFG_DIR1:  r_dir[1]  <= i_cfg_data[1:0];
                    CFG_DIR2:  r_dir[2]  <= i_cfg_data[1:0];
                    CFG_DIST0: r_dist[0] <= i_cfg_data[15:0];
                    CFG_DIST1: r_dist[1] <= i_cfg_data[15:0];
                    CFG_DIST2: r_dist[2] <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_instr <= i_in_data;
            r_rd_a  <= r_rf[i_in_data.field_x];
            r_rd_b  <= r_rf[i_in_data.field_y];
            r_a_vld <= r_rf_vld[i_in_data.field_x];
            r_b_vld <= r_rf_vld[i_in_data.field_y];
        end
        if (w_rf_we) begin
            r_rf[w_rf_wa] <= w_rf_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_res <= n_res;
        end else if ((r_state == S_ITER) && w_rsp.done) begin
            r_res.main_value <= w_rsp.result;
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

endmodule

`default_nettype wire
